// ===== design/abb_pkg.sv =====
// shared types and constants for the assignment branch-and-bound solver
// no dependencies
package abb_pkg;

    localparam int N        = 4;
    localparam int IDX_W    = 2;
    localparam int COST_W   = 10;
    localparam int SUM_W    = 12;
    localparam int DEPTH_W  = $clog2(N + 1);
    localparam int Q_DEPTH  = 64;
    localparam int Q_AW     = $clog2(Q_DEPTH);
    localparam int Q_CW     = $clog2(Q_DEPTH + 1);

    localparam logic [COST_W-1:0] COST_SENTINEL = COST_W'(1001);
    localparam logic [IDX_W-1:0]  LAST_IDX      = IDX_W'(N - 1);

    typedef struct packed {
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [COST_W-1:0] cost;
        logic              last;
    } item_t;

    typedef struct packed {
        logic [SUM_W-1:0] min_cost;
        logic [SUM_W-1:0] lower_bound;
        logic [SUM_W-1:0] upper_bound;
        logic             overflow;
    } result_t;

    typedef struct packed {
        logic [SUM_W-1:0] bound;
        logic [N-1:0]     used;
    } qnode_t;

    typedef struct packed {
        logic             load_en;
        logic             low_en;
        logic             up_en;
        logic             init_en;
        logic             pop_en;
        logic             exp_en;
        logic [IDX_W-1:0] hi;
        logic [IDX_W-1:0] lo;
    } cmd_t;

    typedef struct packed {
        logic q_empty;
        logic leaf;
    } status_t;

endpackage

// ===== design/abb_datapath.sv =====
// datapath: cost matrix, row minima, bound accumulators and search queue
// depends on abb_pkg
module abb_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  abb_pkg::item_t   item,
    input  abb_pkg::cmd_t    cmd,
    output abb_pkg::status_t status,
    output abb_pkg::result_t result
);

    logic [abb_pkg::COST_W-1:0] cost_mem [abb_pkg::N][abb_pkg::N];
    logic [abb_pkg::COST_W-1:0] rowmin_mem [abb_pkg::N];
    abb_pkg::qnode_t            q_mem [abb_pkg::Q_DEPTH];
    abb_pkg::qnode_t            node_reg;

    logic [abb_pkg::SUM_W-1:0]  lower_reg, upper_reg, best_reg;
    logic [abb_pkg::COST_W-1:0] min_reg, min_next;
    logic [abb_pkg::IDX_W-1:0]  pick_reg, pick_next;
    logic [abb_pkg::N-1:0]      taken_reg;
    logic [abb_pkg::Q_AW-1:0]   head_reg;
    logic [abb_pkg::Q_CW-1:0]   count_reg;
    logic                       ovf_reg;

    logic [abb_pkg::COST_W-1:0] v_low, v_up, base_min, base_up, v_exp;
    logic [abb_pkg::DEPTH_W-1:0] depth;
    logic [abb_pkg::IDX_W-1:0]  drow;
    logic [abb_pkg::SUM_W:0]    child_b;
    logic                       child_ok;
    logic                       q_we;
    logic [abb_pkg::Q_AW-1:0]   q_waddr;
    abb_pkg::qnode_t            q_wdata;

    always_comb
    begin
        v_low    = cost_mem[cmd.hi][cmd.lo];
        base_min = (cmd.lo == '0) ? abb_pkg::COST_SENTINEL : min_reg;
        min_next = (v_low < base_min) ? v_low : base_min;

        // greedy pass: column is hi, row is lo
        v_up      = cost_mem[cmd.lo][cmd.hi];
        base_up   = (cmd.lo == '0) ? abb_pkg::COST_SENTINEL : min_reg;
        pick_next = (cmd.lo == '0) ? '0 : pick_reg;
        if (!taken_reg[cmd.lo] && v_up < base_up)
        begin
            pick_next = cmd.lo;
        end
    end

    always_comb
    begin
        depth = '0;
        for (int j = 0; j < abb_pkg::N; j++)
        begin
            depth = depth + abb_pkg::DEPTH_W'(node_reg.used[j]);
        end
        drow    = depth[abb_pkg::IDX_W-1:0];
        v_exp   = cost_mem[drow][cmd.lo];
        child_b = {1'b0, node_reg.bound} + (abb_pkg::SUM_W+1)'(v_exp)
                  - (abb_pkg::SUM_W+1)'(rowmin_mem[drow]);
        child_ok = !node_reg.used[cmd.lo] && (child_b <= {1'b0, upper_reg});

        q_we    = 1'b0;
        q_waddr = head_reg + count_reg[abb_pkg::Q_AW-1:0];
        q_wdata = '{bound: child_b[abb_pkg::SUM_W-1:0],
                    used:  node_reg.used | (abb_pkg::N'(1) << cmd.lo)};
        if (cmd.init_en)
        begin
            q_we    = 1'b1;
            q_waddr = '0;
            q_wdata = '{bound: lower_reg, used: '0};
        end
        else if (cmd.exp_en && !status.leaf && child_ok
                 && count_reg != abb_pkg::Q_CW'(abb_pkg::Q_DEPTH))
        begin
            q_we = 1'b1;
        end
    end

    assign status.q_empty = (count_reg == '0);
    assign status.leaf    = (depth == abb_pkg::DEPTH_W'(abb_pkg::N));

    // storage without reset
    always_ff @(posedge clk)
    begin
        if (cmd.load_en && int'(item.row) < abb_pkg::N && int'(item.col) < abb_pkg::N)
        begin
            cost_mem[item.row][item.col] <= item.cost;
        end
        if (cmd.low_en && cmd.lo == abb_pkg::LAST_IDX)
        begin
            rowmin_mem[cmd.hi] <= min_next;
        end
        if (cmd.low_en)
        begin
            min_reg <= min_next;
        end
        if (cmd.up_en)
        begin
            min_reg  <= (!taken_reg[cmd.lo] && v_up < base_up) ? v_up : base_up;
            pick_reg <= pick_next;
        end
        if (q_we)
        begin
            q_mem[q_waddr] <= q_wdata;
        end
        if (cmd.pop_en)
        begin
            node_reg <= q_mem[head_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg <= '0;
            upper_reg <= '0;
            best_reg  <= '1;
            taken_reg <= '0;
            head_reg  <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load_en && item.last)
            begin
                lower_reg <= '0;
                upper_reg <= '0;
                taken_reg <= '0;
            end
            if (cmd.low_en && cmd.lo == abb_pkg::LAST_IDX)
            begin
                lower_reg <= lower_reg + abb_pkg::SUM_W'(min_next);
            end
            if (cmd.up_en && cmd.lo == abb_pkg::LAST_IDX)
            begin
                upper_reg <= upper_reg + abb_pkg::SUM_W'(
                    (!taken_reg[cmd.lo] && v_up < base_up) ? v_up : base_up);
                taken_reg[pick_next] <= 1'b1;
            end
            if (cmd.init_en)
            begin
                head_reg  <= '0;
                count_reg <= abb_pkg::Q_CW'(1);
                best_reg  <= '1;
                ovf_reg   <= 1'b0;
            end
            if (cmd.pop_en)
            begin
                head_reg  <= head_reg + abb_pkg::Q_AW'(1);
                count_reg <= count_reg - abb_pkg::Q_CW'(1);
            end
            if (cmd.exp_en)
            begin
                if (status.leaf)
                begin
                    if (node_reg.bound < best_reg)
                    begin
                        best_reg <= node_reg.bound;
                    end
                end
                else if (child_ok)
                begin
                    if (count_reg == abb_pkg::Q_CW'(abb_pkg::Q_DEPTH))
                    begin
                        ovf_reg <= 1'b1;
                    end
                    else
                    begin
                        count_reg <= count_reg + abb_pkg::Q_CW'(1);
                    end
                end
            end
        end
    end

    assign result = '{min_cost: best_reg, lower_bound: lower_reg,
                      upper_bound: upper_reg, overflow: ovf_reg};

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= abb_pkg::Q_CW'(abb_pkg::Q_DEPTH))
        else $error("queue count above depth");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_en |-> count_reg != '0)
        else $error("pop from empty queue");
    a_init_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.init_en |=> count_reg == abb_pkg::Q_CW'(1) && !ovf_reg)
        else $error("queue not seeded with root");
`endif

endmodule

// ===== design/abb_controller.sv =====
// controller: sequences load, bound passes and the breadth-first search
// depends on abb_pkg
module abb_controller (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             last,
    input  abb_pkg::status_t status,
    output abb_pkg::cmd_t    cmd,
    output logic             busy,
    output logic             done
);

    typedef enum logic [2:0] {
        S_LOAD, S_LOWER, S_UPPER, S_INIT, S_POP, S_EXPAND, S_DONE
    } state_t;

    state_t                    state_reg;
    logic [abb_pkg::IDX_W-1:0] hi_reg, lo_reg;

    always_comb
    begin
        cmd         = '0;
        cmd.hi      = hi_reg;
        cmd.lo      = lo_reg;
        cmd.load_en = (state_reg == S_LOAD) && start;
        cmd.low_en  = (state_reg == S_LOWER);
        cmd.up_en   = (state_reg == S_UPPER);
        cmd.init_en = (state_reg == S_INIT);
        cmd.pop_en  = (state_reg == S_POP) && !status.q_empty;
        cmd.exp_en  = (state_reg == S_EXPAND);
    end

    assign busy = (state_reg != S_LOAD);
    assign done = (state_reg == S_DONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            hi_reg    <= '0;
            lo_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_LOAD:
                begin
                    hi_reg <= '0;
                    lo_reg <= '0;
                    if (start && last)
                    begin
                        state_reg <= S_LOWER;
                    end
                end
                S_LOWER, S_UPPER:
                begin
                    if (lo_reg == abb_pkg::LAST_IDX)
                    begin
                        lo_reg <= '0;
                        if (hi_reg == abb_pkg::LAST_IDX)
                        begin
                            hi_reg    <= '0;
                            state_reg <= (state_reg == S_LOWER) ? S_UPPER : S_INIT;
                        end
                        else
                        begin
                            hi_reg <= hi_reg + abb_pkg::IDX_W'(1);
                        end
                    end
                    else
                    begin
                        lo_reg <= lo_reg + abb_pkg::IDX_W'(1);
                    end
                end
                S_INIT:
                begin
                    state_reg <= S_POP;
                end
                S_POP:
                begin
                    lo_reg    <= '0;
                    state_reg <= status.q_empty ? S_DONE : S_EXPAND;
                end
                S_EXPAND:
                begin
                    // a leaf goes straight back to S_POP, an inner node steps lo through every column first
                    if (status.leaf || lo_reg == abb_pkg::LAST_IDX)
                    begin
                        state_reg <= S_POP;
                    end
                    else
                    begin
                        lo_reg <= lo_reg + abb_pkg::IDX_W'(1);
                    end
                end
                S_DONE:
                begin
                    state_reg <= S_LOAD;
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy after result beat");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat longer than one cycle");
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_en, cmd.low_en, cmd.up_en, cmd.init_en, cmd.pop_en, cmd.exp_en}))
        else $error("overlapping datapath commands");
`endif

endmodule

// ===== design/assignment_branch_and_bound.sv =====
// Exact 4x4 assignment solver by branch and bound.
// Input beat: start with busy low accepts one cost entry {row, col, cost, last}.
// Entries are stored one per cycle; an entry with last set is stored and then
// starts a solve, during which busy stays high and start is ignored.
// Solve: the row-minimum lower bound pass, the greedy upper bound pass, the
// queue seed, then per queued node a pop followed by a leaf check for a
// complete assignment or a column-by-column expansion of its children,
// then one more pop that finds the queue empty and a state with done high
// carrying the result beat. The search queue is a 64-entry memory with
// one write and one registered read per cycle; its node count sets the search
// length (at most 65 nodes pass through it for 4x4).
// Result: min_cost, lower_bound, upper_bound and overflow; overflow set means
// children were dropped on a full queue. done lasts exactly one cycle and the
// receiver must take it then. Entries without last give no result beat.
// Reset clears the controller and bounds; the cost matrix must be fully
// written before the first solve.
// Depends on abb_pkg, abb_controller, abb_datapath.
module assignment_branch_and_bound (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  abb_pkg::item_t   item,
    output logic             busy,
    output logic             done,
    output abb_pkg::result_t result
);

    abb_pkg::cmd_t    cmd;
    abb_pkg::status_t status;

    abb_controller u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .last   (item.last),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    abb_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

endmodule

// ===== verif/abb_checker.sv =====
`timescale 1ns / 1ps
// beat monitor and solve predictor for the assignment branch-and-bound solver
// depends on abb_pkg; instantiated by tb_top beside the block
module abb_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  abb_pkg::item_t   item,
    input  logic             done,
    input  abb_pkg::result_t result,
    output int               fails,
    output int               pending
);

    localparam int unsigned SENT = 1001;
    localparam int unsigned OMAX = 4095;

    int unsigned      cost_mat [abb_pkg::N][abb_pkg::N];
    abb_pkg::result_t want_q [$];

    assign pending = want_q.size();

    function automatic int unsigned clip12(int unsigned v);
        return (v > OMAX) ? OMAX : v;
    endfunction

    // lower bound, greedy upper bound, then breadth-first search with a bounded queue
    function automatic abb_pkg::result_t solve_assignment();
        int unsigned      rmin [abb_pkg::N];
        int unsigned      lo, hi, best, m, b, depth;
        int unsigned      qb [abb_pkg::Q_DEPTH];
        int unsigned      qu [abb_pkg::Q_DEPTH];
        int unsigned      head, cnt, nb, nu;
        int               pick;
        bit               taken [abb_pkg::N];
        bit               ovf;
        abb_pkg::result_t res;
        lo = 0;
        for (int r = 0; r < abb_pkg::N; r++)
        begin
            m = SENT;
            for (int c = 0; c < abb_pkg::N; c++)
                if (cost_mat[r][c] < m) m = cost_mat[r][c];
            rmin[r] = m;
            lo += m;
        end
        hi = 0;
        for (int r = 0; r < abb_pkg::N; r++) taken[r] = 0;
        for (int c = 0; c < abb_pkg::N; c++)
        begin
            m = SENT;
            pick = 0;
            for (int r = 0; r < abb_pkg::N; r++)
                if (!taken[r] && cost_mat[r][c] < m)
                begin
                    m = cost_mat[r][c];
                    pick = r;
                end
            hi += m;
            taken[pick] = 1;
        end
        best = 32'hFFFF_FFFF;
        ovf = 0;
        head = 0;
        qb[0] = lo;
        qu[0] = 0;
        cnt = 1;
        while (cnt != 0)
        begin
            nb = qb[head];
            nu = qu[head];
            head = (head + 1) % abb_pkg::Q_DEPTH;
            cnt--;
            depth = $countones(nu[abb_pkg::N-1:0]);
            if (depth >= abb_pkg::N)
            begin
                if (nb < best) best = nb;
                continue;
            end
            for (int j = 0; j < abb_pkg::N; j++)
                if (!nu[j])
                begin
                    b = cost_mat[depth][j] + nb - rmin[depth];
                    if (b <= hi)
                    begin
                        if (cnt >= abb_pkg::Q_DEPTH)
                            ovf = 1;
                        else
                        begin
                            qb[(head + cnt) % abb_pkg::Q_DEPTH] = b;
                            qu[(head + cnt) % abb_pkg::Q_DEPTH] = nu | (1 << j);
                            cnt++;
                        end
                    end
                end
        end
        res.min_cost    = abb_pkg::SUM_W'(clip12(best));
        res.lower_bound = abb_pkg::SUM_W'(clip12(lo));
        res.upper_bound = abb_pkg::SUM_W'(clip12(hi));
        res.overflow    = ovf;
        return res;
    endfunction

    task automatic report(string what, int unsigned got, int unsigned exp_v);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_v, $realtime);
        fails++;
    endtask

    initial fails = 0;

    always @(posedge clk)
    begin
        abb_pkg::result_t w;
        if (rst_n)
        begin
            if (done)
            begin
                if (want_q.size() == 0)
                    report("unexpected result beat", 1, 0);
                else
                begin
                    w = want_q.pop_front();
                    if (result.min_cost != w.min_cost)
                        report("min_cost", result.min_cost, w.min_cost);
                    if (result.lower_bound != w.lower_bound)
                        report("lower_bound", result.lower_bound, w.lower_bound);
                    if (result.upper_bound != w.upper_bound)
                        report("upper_bound", result.upper_bound, w.upper_bound);
                    if (result.overflow != w.overflow)
                        report("overflow", result.overflow, w.overflow);
                end
            end
            if (start && !busy)
            begin
                cost_mat[item.row][item.col] = item.cost;
                if (item.last) want_q.push_back(solve_assignment());
            end
        end
    end
endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// stimulus and verdict for the assignment branch-and-bound solver
// depends on abb_pkg, assignment_branch_and_bound and abb_checker
module tb_top;

    localparam int LIMIT = 1000000;

    logic             clk = 0;
    logic             rst_n = 0;
    logic             start = 0;
    abb_pkg::item_t   item = '0;
    logic             busy, done;
    abb_pkg::result_t result;
    int               fails, pending;
    int               cycles = 0;
    int               idle_pct = 0;

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    assignment_branch_and_bound u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .item(item),
        .busy(busy), .done(done), .result(result)
    );

    abb_checker u_chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .fails(fails), .pending(pending)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic send_entry(int r, int c, int v, bit lst);
        abb_pkg::item_t it;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        it.row  = abb_pkg::IDX_W'(r);
        it.col  = abb_pkg::IDX_W'(c);
        it.cost = abb_pkg::COST_W'(v);
        it.last = lst;
        start <= 1;
        item  <= it;
        do @(posedge clk); while (busy);
    endtask

    function automatic int pick_cost();
        int k;
        k = $urandom_range(99);
        if (k < 55) return $urandom_range(1000);
        if (k < 85) return $urandom_range(7);
        return $urandom_range(1001, 1023);
    endfunction

    initial
    begin
        int n;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        idle_pct = 16;
        // full fill, both cost extremes, solve on the last beat
        for (int i = 0; i < abb_pkg::N * abb_pkg::N; i++)
            send_entry(i / abb_pkg::N, i % abb_pkg::N,
                       (i == 0) ? 0 : ((i == 5) ? 1000 : i * 37),
                       i == abb_pkg::N * abb_pkg::N - 1);
        // a row with nothing below the sentinel
        send_entry(1, 0, 1023, 0);
        send_entry(1, 1, 1001, 0);
        send_entry(1, 2, 1010, 0);
        send_entry(1, 3, 1005, 1);
        send_entry(3, 3, 0, 1);
        for (int k = 0; k < 400; )
        begin
            if (k > 130) idle_pct = 75;
            if (k > 260) idle_pct = 0;
            if ($urandom_range(9) == 0)
            begin
                // equal costs everywhere gives the widest search
                n = $urandom_range(3);
                for (int i = 0; i < abb_pkg::N * abb_pkg::N; i++)
                    send_entry(i / abb_pkg::N, i % abb_pkg::N, n,
                               i == abb_pkg::N * abb_pkg::N - 1);
                k += abb_pkg::N * abb_pkg::N;
            end
            else
            begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    send_entry($urandom_range(3), $urandom_range(3), pick_cost(), i == n - 1);
                k += n;
            end
        end
        start <= 0;
        while (pending != 0) @(posedge clk);
        repeat (500) @(posedge clk);
        if (fails == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule

// ===== sim.f =====
design/abb_pkg.sv
design/abb_datapath.sv
design/abb_controller.sv
design/assignment_branch_and_bound.sv
verif/abb_checker.sv
verif/tb_top.sv
